// ===== hw/rtl/line_rect_rasterizer_macros.svh =====
// ----------------------------------------------------------------------------
// line_rect_rasterizer assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LINE_RECT_RASTERIZER_MACROS_SVH
`define LINE_RECT_RASTERIZER_MACROS_SVH

// plain invariant
`define LRR_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define LRR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LRR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lrr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrr_pkg
// Shared types and constants of the line and rectangle rasterizer.
// ----------------------------------------------------------------------------
package lrr_pkg;

    localparam int FB_WIDTH_DEF  = 64;
    localparam int FB_HEIGHT_DEF = 64;
    localparam int COLOR_W       = 24;
    localparam int COORD_W       = 12;
    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = 1;
    localparam int QCNT_W        = 2;
    localparam int DIV_W         = 24;

    localparam logic [1:0] FUNC_LINE = 2'd0;
    localparam logic [1:0] FUNC_RECT = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    typedef struct packed {
        logic                      en;
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] d;
        logic signed [COORD_W-1:0] base;
        logic signed [COORD_W-1:0] obase;
        logic signed [COORD_W-1:0] start;
        logic signed [COORD_W-1:0] stop;
    } pass_t;

    typedef struct packed {
        logic                      en;
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
    } rect_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [COLOR_W-1:0] color;
        pass_t              p1;
        pass_t              p2;
        rect_t              rect;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_out_t;

endpackage

// ===== hw/rtl/lrr_ram.sv =====
// ----------------------------------------------------------------------------
// lrr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module lrr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/lrr_front.sv =====
// ----------------------------------------------------------------------------
// lrr_front
// Accepts commands, orders line endpoints, clamps rectangles, queues words.
// ----------------------------------------------------------------------------
`include "line_rect_rasterizer_macros.svh"

module lrr_front #(
    parameter int FB_HEIGHT = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   func,
    input  logic signed [10:0]           x0,
    input  logic signed [10:0]           y0,
    input  logic signed [10:0]           x1,
    input  logic signed [10:0]           y1,
    input  logic [lrr_pkg::COLOR_W-1:0]  draw_color,
    input  logic                         pop,
    output lrr_pkg::q_out_t              q_out
);
    import lrr_pkg::*;

    localparam logic signed [COORD_W-1:0] YMAX = COORD_W'(FB_HEIGHT - 1);
    localparam logic signed [COORD_W-1:0] ONE  = COORD_W'(1);

    cmd_t               q_mem [QDEPTH];
    logic [QPTR_W-1:0]  wp_reg, wp_next, rp_reg, rp_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               push, do_pop;
    cmd_t               cmd;

    logic signed [COORD_W-1:0] ix0, iy0, ix1, iy1;
    logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy, ex, ey;
    logic signed [COORD_W-1:0] dx1, dy1, dx2, dy2;
    logic signed [COORD_W-1:0] rx0, ry0, ry1;

    always_comb
    begin
        ix0 = COORD_W'(x0);
        iy0 = COORD_W'(y0);
        ix1 = COORD_W'(x1);
        iy1 = COORD_W'(y1);
        if (iy0 < iy1)
        begin
            ax = ix1; ay = iy1; bx = ix0; by = iy0;
        end
        else
        begin
            ax = ix0; ay = iy0; bx = ix1; by = iy1;
        end
        dx1 = bx - ax;
        dy1 = by - ay;
        if (ax > bx)
        begin
            cx = bx; cy = by; ex = ax; ey = ay;
        end
        else
        begin
            cx = ax; cy = ay; ex = bx; ey = by;
        end
        dx2 = ex - cx;
        dy2 = ey - cy;
        rx0 = (ix0 < 0) ? '0 : ix0;
        ry0 = (iy0 < 0) ? '0 : iy0;
        ry1 = (iy1 > YMAX) ? YMAX : iy1;

        cmd.func     = func;
        cmd.color    = draw_color;
        cmd.p1.en    = (dx1 >= dy1);
        cmd.p1.a     = dx1;
        cmd.p1.d     = (dy1 == 0) ? ONE : dy1;
        cmd.p1.base  = ay;
        cmd.p1.obase = ax;
        cmd.p1.start = ay;
        cmd.p1.stop  = by;
        cmd.p2.en    = (cx < ex);
        cmd.p2.a     = dy2;
        cmd.p2.d     = (dx2 == 0) ? ONE : dx2;
        cmd.p2.base  = cx;
        cmd.p2.obase = cy;
        cmd.p2.start = cx + ONE;
        cmd.p2.stop  = ex;
        cmd.rect.en  = (rx0 <= ix1) && (ry0 <= ry1);
        cmd.rect.x0  = (func == FUNC_READ) ? ix0 : rx0;
        cmd.rect.y0  = (func == FUNC_READ) ? iy0 : ry0;
        cmd.rect.x1  = ix1;
        cmd.rect.y1  = ry1;
    end

    assign in_stall    = (cnt_reg == QCNT_W'(QDEPTH));
    assign push        = in_valid && !in_stall;
    assign do_pop      = pop && (cnt_reg != '0);
    assign q_out.valid = (cnt_reg != '0);
    assign q_out.cmd   = q_mem[rp_reg];

    always_comb
    begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = do_pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wp_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    `LRR_ASSERT(a_q_max, cnt_reg <= QCNT_W'(QDEPTH), "queue over depth")
    `LRR_ASSERT_NXT(a_q_inc, push && !do_pop, cnt_reg == $past(cnt_reg) + 1'b1, "push lost")
    `LRR_ASSERT_NXT(a_q_dec, do_pop && !push, cnt_reg == $past(cnt_reg) - 1'b1, "pop lost")
endmodule

// ===== hw/rtl/lrr_back.sv =====
// ----------------------------------------------------------------------------
// lrr_back
// Executes queued words: line passes with a serial divider, rectangle fill,
// pixel read, and the frame store clear after reset. Holds the result register.
// ----------------------------------------------------------------------------
`include "line_rect_rasterizer_macros.svh"

module lrr_back #(
    parameter int FB_WIDTH  = 64,
    parameter int FB_HEIGHT = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lrr_pkg::q_out_t              q_out,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [lrr_pkg::COLOR_W-1:0]  read_color,
    output logic                         read_valid
);
    import lrr_pkg::*;

    localparam int FB_SIZE = FB_WIDTH * FB_HEIGHT;
    localparam int ADDR_W  = $clog2(FB_SIZE);
    localparam int SUM_W   = $clog2(FB_WIDTH) + 13;
    localparam int DCNT_W  = $clog2(DIV_W);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_DIVI  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_FIN   = 4'd5;
    localparam logic [3:0] S_WR    = 4'd6;
    localparam logic [3:0] S_RDA   = 4'd7;
    localparam logic [3:0] S_RDD   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]                state_reg, state_next;
    logic [ADDR_W-1:0]         clr_reg, clr_next;
    cmd_t                      cmd_reg, cmd_next;
    logic                      pass_reg, pass_next;
    logic signed [COORD_W-1:0] a_reg, a_next, d_reg, d_next;
    logic signed [COORD_W-1:0] base_reg, base_next, obase_reg, obase_next;
    logic signed [COORD_W-1:0] v_reg, v_next, stop_reg, stop_next;
    logic signed [COORD_W-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [24:0]        prod_reg, prod_next;
    logic [DIV_W-1:0]          num_reg, num_next;
    logic [10:0]               rem_reg, rem_next, den_reg, den_next;
    logic                      neg_reg, neg_next;
    logic [DCNT_W-1:0]         dcnt_reg, dcnt_next;
    logic                      rok_reg, rok_next;
    logic                      ov_reg, ov_next;
    logic [COLOR_W-1:0]        rc_reg, rc_next, res_c_reg, res_c_next;
    logic                      rv_reg, rv_next, res_v_reg, res_v_next;

    logic signed [12:0]        diff, qs, coord;
    logic signed [24:0]        pabs;
    logic signed [COORD_W-1:0] dabs;
    logic [11:0]               rem_sh;
    logic                      ge;
    logic [SUM_W-1:0]          sum;
    logic                      in_fb;
    logic                      ram_we;
    logic [ADDR_W-1:0]         waddr;
    logic [COLOR_W-1:0]        wdata, rdata;

    lrr_ram #(.WIDTH(COLOR_W), .DEPTH(FB_SIZE)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (sum[ADDR_W-1:0]),
        .rdata (rdata)
    );

    assign diff   = 13'(v_reg) - 13'(base_reg);
    assign pabs   = prod_reg[24] ? -prod_reg : prod_reg;
    assign dabs   = d_reg[COORD_W-1] ? -d_reg : d_reg;
    assign rem_sh = {rem_reg, num_reg[DIV_W-1]};
    assign ge     = (rem_sh >= {1'b0, den_reg});
    assign qs     = neg_reg ? -$signed({1'b0, num_reg[11:0]}) : $signed({1'b0, num_reg[11:0]});
    assign coord  = 13'(obase_reg) + qs;
    assign sum    = SUM_W'(px_reg[10:0]) + SUM_W'(py_reg[10:0]) * SUM_W'(FB_WIDTH);
    assign in_fb  = !px_reg[COORD_W-1] && !py_reg[COORD_W-1] && (sum < SUM_W'(FB_SIZE));
    assign ram_we = (state_reg == S_CLEAR) || ((state_reg == S_WR) && in_fb);
    assign waddr  = (state_reg == S_CLEAR) ? clr_reg : sum[ADDR_W-1:0];
    assign wdata  = (state_reg == S_CLEAR) ? '0 : cmd_reg.color;
    assign pop    = (state_reg == S_IDLE) && q_out.valid;

    assign out_valid  = ov_reg;
    assign read_color = rc_reg;
    assign read_valid = rv_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cmd_next   = cmd_reg;
        pass_next  = pass_reg;
        a_next     = a_reg;
        d_next     = d_reg;
        base_next  = base_reg;
        obase_next = obase_reg;
        v_next     = v_reg;
        stop_next  = stop_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        prod_next  = prod_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        dcnt_next  = dcnt_reg;
        rok_next   = rok_reg;
        res_c_next = res_c_reg;
        res_v_next = res_v_reg;
        ov_next    = ov_reg && out_stall;
        rc_next    = rc_reg;
        rv_next    = rv_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(FB_SIZE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_out.valid)
                begin
                    cmd_next   = q_out.cmd;
                    res_c_next = '0;
                    res_v_next = 1'b0;
                    px_next    = q_out.cmd.rect.x0;
                    py_next    = q_out.cmd.rect.y0;
                    case (q_out.cmd.func)
                        FUNC_LINE:
                        begin
                            if (q_out.cmd.p1.en || q_out.cmd.p2.en)
                            begin
                                pass_next  = !q_out.cmd.p1.en;
                                a_next     = q_out.cmd.p1.en ? q_out.cmd.p1.a : q_out.cmd.p2.a;
                                d_next     = q_out.cmd.p1.en ? q_out.cmd.p1.d : q_out.cmd.p2.d;
                                base_next  = q_out.cmd.p1.en ? q_out.cmd.p1.base
                                                             : q_out.cmd.p2.base;
                                obase_next = q_out.cmd.p1.en ? q_out.cmd.p1.obase
                                                             : q_out.cmd.p2.obase;
                                v_next     = q_out.cmd.p1.en ? q_out.cmd.p1.start
                                                             : q_out.cmd.p2.start;
                                stop_next  = q_out.cmd.p1.en ? q_out.cmd.p1.stop
                                                             : q_out.cmd.p2.stop;
                                state_next = S_MUL;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        FUNC_RECT:
                            state_next = q_out.cmd.rect.en ? S_WR : S_DONE;
                        FUNC_READ:
                            state_next = S_RDA;
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_MUL:
            begin
                prod_next  = 25'(a_reg) * 25'(diff);
                state_next = S_DIVI;
            end
            S_DIVI:
            begin
                num_next   = pabs[DIV_W-1:0];
                den_next   = dabs[10:0];
                neg_next   = prod_reg[24] ^ d_reg[COORD_W-1];
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next  = ge ? 11'(rem_sh - {1'b0, den_reg}) : rem_sh[10:0];
                num_next  = {num_reg[DIV_W-2:0], ge};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(DIV_W - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                px_next    = pass_reg ? v_reg : coord[COORD_W-1:0];
                py_next    = pass_reg ? coord[COORD_W-1:0] : v_reg;
                state_next = S_WR;
            end
            S_WR:
            begin
                if (cmd_reg.func == FUNC_RECT)
                begin
                    if (py_reg == cmd_reg.rect.y1)
                    begin
                        py_next = cmd_reg.rect.y0;
                        px_next = px_reg + 1'b1;
                        if (px_reg == cmd_reg.rect.x1)
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        py_next = py_reg + 1'b1;
                    end
                end
                else if (v_reg == stop_reg)
                begin
                    if (!pass_reg && cmd_reg.p2.en)
                    begin
                        pass_next  = 1'b1;
                        a_next     = cmd_reg.p2.a;
                        d_next     = cmd_reg.p2.d;
                        base_next  = cmd_reg.p2.base;
                        obase_next = cmd_reg.p2.obase;
                        v_next     = cmd_reg.p2.start;
                        stop_next  = cmd_reg.p2.stop;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    v_next     = pass_reg ? v_reg + 1'b1 : v_reg - 1'b1;
                    state_next = S_MUL;
                end
            end
            S_RDA:
            begin
                rok_next   = in_fb;
                state_next = S_RDD;
            end
            S_RDD:
            begin
                res_c_next = rok_reg ? rdata : '0;
                res_v_next = rok_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    rc_next    = res_c_reg;
                    rv_next    = res_v_reg;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        pass_reg  <= pass_next;
        a_reg     <= a_next;
        d_reg     <= d_next;
        base_reg  <= base_next;
        obase_reg <= obase_next;
        v_reg     <= v_next;
        stop_reg  <= stop_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        prod_reg  <= prod_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        neg_reg   <= neg_next;
        dcnt_reg  <= dcnt_next;
        rok_reg   <= rok_next;
        res_c_reg <= res_c_next;
        res_v_reg <= res_v_next;
        rc_reg    <= rc_next;
        rv_reg    <= rv_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    `LRR_ASSERT_IMP(a_we_state, ram_we, (state_reg == S_CLEAR) || (state_reg == S_WR), "stray write")
    `LRR_ASSERT_IMP(a_div_cnt, state_reg == S_DIV, dcnt_reg < DCNT_W'(DIV_W), "divider overrun")
    `LRR_ASSERT_NXT(a_res_load, (state_reg == S_DONE) && (!ov_reg || !out_stall), ov_reg, "result lost")
endmodule

// ===== hw/rtl/line_rect_rasterizer.sv =====
// ----------------------------------------------------------------------------
// line_rect_rasterizer
// Line, rectangle and pixel read commands over a 24-bit color frame store.
//
//   port group   dir  handshake            word
//   command      in   in_valid / in_stall  func, x0, y0, x1, y1, draw_color
//   result       out  out_valid/out_stall  read_color, read_valid
//
// Line: per point S_MUL, S_DIVI, the 24-step serial divider, S_FIN, S_WR.
// Rectangle: one covered pixel per cycle, set by the frame store write port.
// Read: S_RDA, then S_RDD, then S_DONE; every word ends with one result word.
// After reset all FB_WIDTH*FB_HEIGHT store words are cleared; commands
// queue (two deep) meanwhile. A stalled result holds the executor only.
// ----------------------------------------------------------------------------
module line_rect_rasterizer #(
    parameter int FB_WIDTH  = lrr_pkg::FB_WIDTH_DEF,
    parameter int FB_HEIGHT = lrr_pkg::FB_HEIGHT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   func,
    input  logic signed [10:0]           x0,
    input  logic signed [10:0]           y0,
    input  logic signed [10:0]           x1,
    input  logic signed [10:0]           y1,
    input  logic [lrr_pkg::COLOR_W-1:0]  draw_color,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [lrr_pkg::COLOR_W-1:0]  read_color,
    output logic                         read_valid
);
    import lrr_pkg::*;

    q_out_t q_out;
    logic   pop;

    lrr_front #(.FB_HEIGHT(FB_HEIGHT)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .x0         (x0),
        .y0         (y0),
        .x1         (x1),
        .y1         (y1),
        .draw_color (draw_color),
        .pop        (pop),
        .q_out      (q_out)
    );

    lrr_back #(.FB_WIDTH(FB_WIDTH), .FB_HEIGHT(FB_HEIGHT)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_out      (q_out),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_color (read_color),
        .read_valid (read_valid)
    );
endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: line and rectangle rasterizer testbench
// Drives line, rectangle and pixel read commands through the valid/stall
// command port. A local copy of the 64x64 frame store predicts every result
// word, and each result word is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lrr_pkg::*;

    localparam int          FBW        = 64;
    localparam int          FBH        = 64;
    localparam int          FB_PIXELS  = FBW * FBH;
    localparam logic [1:0]  FUNC_NONE  = 2'd3;
    localparam int          STALL_LIMIT = 400000;

    typedef struct {
        logic [COLOR_W-1:0] color;
        logic               hit;
    } pixel_read_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          func = '0;
    logic signed [10:0]  x0 = '0;
    logic signed [10:0]  y0 = '0;
    logic signed [10:0]  x1 = '0;
    logic signed [10:0]  y1 = '0;
    logic [COLOR_W-1:0]  draw_color = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [COLOR_W-1:0]  read_color;
    logic                read_valid;

    logic [COLOR_W-1:0]  shadow_fb [FB_PIXELS];
    pixel_read_t         pending_reads [$];
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  hold_left = 0;
    int                  mismatches = 0;
    int                  words_sent = 0;
    int                  words_checked = 0;
    int                  quiet_cycles = 0;

    line_rect_rasterizer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .x0         (x0),
        .y0         (y0),
        .x1         (x1),
        .y1         (y1),
        .draw_color (draw_color),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_color (read_color),
        .read_valid (read_valid)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit fb_index(input int x, input int y, output int idx);
        if (x < 0 || y < 0 || x + y * FBW >= FB_PIXELS)
            return 1'b0;
        idx = x + y * FBW;
        return 1'b1;
    endfunction

    function automatic void plot(input int x, input int y, input logic [COLOR_W-1:0] c);
        int idx;
        if (fb_index(x, y, idx))
            shadow_fb[idx] = c;
    endfunction

    function automatic void raster_line(input int ax, input int ay, input int bx,
                                        input int by, input logic [COLOR_W-1:0] c);
        int t;
        int d;
        if (ay < by)
        begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
        end
        if ((bx - ax) >= (by - ay))
        begin
            d = (by - ay == 0) ? 1 : (by - ay);
            for (int y = ay; y >= by; y--)
                plot(ax + ((bx - ax) * (y - ay)) / d, y, c);
        end
        if (ax > bx)
        begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
        end
        d = (bx - ax == 0) ? 1 : (bx - ax);
        for (int x = ax + 1; x <= bx; x++)
            plot(x, ay + ((by - ay) * (x - ax)) / d, c);
    endfunction

    function automatic void raster_rect(input int ax, input int ay, input int bx,
                                        input int by, input logic [COLOR_W-1:0] c);
        if (ax < 0) ax = 0;
        if (ay < 0) ay = 0;
        if (by > FBH - 1) by = FBH - 1;
        for (int x = ax; x <= bx; x++)
            for (int y = ay; y <= by; y++)
                plot(x, y, c);
    endfunction

    function automatic pixel_read_t predict_command(input logic [1:0] f, input int ax,
                                                    input int ay, input int bx, input int by,
                                                    input logic [COLOR_W-1:0] c);
        pixel_read_t r;
        int idx;
        r.color = '0;
        r.hit   = 1'b0;
        case (f)
            FUNC_LINE: raster_line(ax, ay, bx, by, c);
            FUNC_RECT: raster_rect(ax, ay, bx, by, c);
            FUNC_READ:
                if (fb_index(ax, ay, idx))
                begin
                    r.color = shadow_fb[idx];
                    r.hit   = 1'b1;
                end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_command(input logic [1:0] f, input int ax, input int ay,
                                input int bx, input int by, input logic [COLOR_W-1:0] c);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct)
            gap = $urandom_range(6, 1);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        func       <= f;
        x0         <= ax[10:0];
        y0         <= ay[10:0];
        x1         <= bx[10:0];
        y1         <= by[10:0];
        draw_color <= c;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_reads.push_back(predict_command(f, ax, ay, bx, by, c));
        words_sent++;
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        pixel_read_t exp_word;
        if (rst_n && out_valid && !out_stall)
        begin
            words_checked++;
            if (pending_reads.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result word color=%h valid=%b",
                             read_color, read_valid);
            end
            else
            begin
                exp_word = pending_reads.pop_front();
                if (read_color !== exp_word.color || read_valid !== exp_word.hit)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d exp color=%h valid=%b got color=%h valid=%b",
                                 words_checked, exp_word.color, exp_word.hit,
                                 read_color, read_valid);
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // watchdog on cycles with no handshake on either port
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TIMEOUT: no handshake for %0d cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int pick_coord(input bit wide);
        if (wide)
            return $signed(11'($urandom));
        return $urandom_range(74) - 4;
    endfunction

    task automatic test_directed;
        send_command(FUNC_READ, 0, 0, 0, 0, 24'hFFFFFF);
        send_command(FUNC_READ, 63, 63, 0, 0, 24'h0);
        send_command(FUNC_RECT, -1024, -1024, 1023, 1023, 24'hA5A5A5);
        send_command(FUNC_READ, 17, 40, 0, 0, 24'h0);
        send_command(FUNC_RECT, 10, 10, 5, 20, 24'hFFFFFF);
        send_command(FUNC_RECT, 10, 20, 15, 10, 24'hFFFFFF);
        send_command(FUNC_READ, 10, 10, 0, 0, 24'h0);
        send_command(FUNC_LINE, 3, 3, 3, 3, 24'h123456);
        send_command(FUNC_LINE, 5, 2, 5, 30, 24'h00FF00);
        send_command(FUNC_LINE, 2, 7, 40, 7, 24'hFF0000);
        send_command(FUNC_LINE, 60, 1, 1, 50, 24'h0000FF);
        send_command(FUNC_LINE, -5, -5, 20, 70, 24'h5A5A5A);
        send_command(FUNC_LINE, -1024, -1024, 1023, 1023, 24'hC3C3C3);
        send_command(FUNC_READ, 5, 15, 0, 0, 24'h0);
        send_command(FUNC_READ, 20, 7, 0, 0, 24'h0);
        send_command(FUNC_READ, 30, 30, 0, 0, 24'h0);
        send_command(FUNC_RECT, 62, 3, 70, 4, 24'h0F0F0F);
        send_command(FUNC_READ, 66, 3, 0, 0, 24'h0);
        send_command(FUNC_READ, 64, 63, 0, 0, 24'h0);
        send_command(FUNC_READ, -1, 0, 0, 0, 24'h0);
        send_command(FUNC_READ, 0, -1024, 0, 0, 24'h0);
        send_command(FUNC_READ, 1023, 1023, 0, 0, 24'h0);
        send_command(FUNC_NONE, 1, 1, 2, 2, 24'hFFFFFF);
        send_command(FUNC_READ, 1, 1, 0, 0, 24'h0);
    endtask

    task automatic test_random(input int n, input int s_pct, input int r_pct);
        int roll;
        logic [1:0] f;
        bit wide;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(99);
            f = roll < 35 ? FUNC_READ : roll < 65 ? FUNC_LINE :
                roll < 95 ? FUNC_RECT : FUNC_NONE;
            if (f == FUNC_LINE || f == FUNC_RECT)
                wide = ($urandom_range(99) < 4);
            else
                wide = ($urandom_range(99) < 30);
            send_command(f, pick_coord(wide), pick_coord(wide), pick_coord(wide),
                         pick_coord(wide), 24'($urandom));
        end
    endtask

    task automatic test_backpressure;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 300;
        for (int i = 0; i < 8; i++)
            send_command(FUNC_READ, $urandom_range(63), $urandom_range(63), 0, 0, 24'h0);
    endtask

    initial
    begin
        foreach (shadow_fb[i])
            shadow_fb[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(40, 33, 75);
        test_backpressure();
        test_random(40, 75, 33);
        test_random(40, 0, 0);
        in_valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Sent %0d command words, checked %0d result words (lines, rects, reads).",
                 words_sent, words_checked);
        $display("Covered clipping, wrap past row end, empty rects and receiver hold-off.");
        if (mismatches == 0 && pending_reads.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== line_rect_rasterizer.f =====
+incdir+hw/rtl
hw/rtl/lrr_pkg.sv
hw/rtl/lrr_ram.sv
hw/rtl/lrr_front.sv
hw/rtl/lrr_back.sv
hw/rtl/line_rect_rasterizer.sv
tb/sv/tb_top.sv
